// ----- hw/rtl/lda_pkg.sv -----
// Shared types, load-kind codes and helpers for the load data aligner.
// No dependencies; imported by every lda_* module.
`timescale 1ns / 1ps
`default_nettype none

package lda_pkg;

   typedef enum logic [3:0] {
      FN_LB   = 4'd0,
      FN_LBU  = 4'd1,
      FN_LH   = 4'd2,
      FN_LHU  = 4'd3,
      FN_LW   = 4'd4,
      FN_LWU  = 4'd5,
      FN_LWC1 = 4'd6,
      FN_LD   = 4'd7,
      FN_LWL  = 4'd8,
      FN_LWR  = 4'd9,
      FN_LDL  = 4'd10,
      FN_LDR  = 4'd11
   } func_type;

   typedef enum logic [1:0] {
      EXT_KEEP,
      EXT_ZERO,
      EXT_SIGN
   } ext_mode_type;

   typedef enum logic [1:0] {
      WID_BYTE,
      WID_HALF,
      WID_WORD
   } ext_width_type;

   // Per-transaction control carried down the pipe.
   typedef struct packed {
      logic          shift_left;
      logic [2:0]    shift_bytes;
      logic [7:0]    byte_mask;   // bytes taken from the shifted data
      ext_mode_type  ext_mode;
      ext_width_type ext_width;
   } ctl_type;

   localparam int DATA_W = 64;

   // Mask of the n lowest bytes, n in 0..8.
   function automatic logic [7:0] low_byte_mask(input logic [3:0] n);
      logic [8:0] m;
      m = (9'd1 << n) - 9'd1;
      return m[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/load_data_aligner_top.sv -----
// Top level of the load data aligner: three-stage pipeline and its valid/stall control.
// Depends on lda_pkg, lda_decode, lda_shift, lda_merge.
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  func, byte_offset, memory_dword, read_ok, old_register
//   rsp_      out   rsp_valid/rsp_stall  load_result
//
// rsp_valid rises once the accepted transaction has passed the decode, shift and merge
// registers. One transaction per cycle while rsp_stall stays low.
// Stages: decode/word select, byte shifter, merge/extend into the output register.
// Each stage advances when empty or when the stage after it advances, so bubbles
// collapse and rsp_stall holds the pipe without losing a transaction.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module load_data_aligner_top
   import lda_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_func,
   input  wire logic [2:0]  req_byte_offset,
   input  wire logic [63:0] req_memory_dword,
   input  wire logic        req_read_ok,
   input  wire logic [63:0] req_old_register,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_load_result
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_en, s2_en, s3_en;

   ctl_type           s1_ctl, s2_ctl;
   logic [DATA_W-1:0] s1_src, s1_old, s2_shifted, s2_old;

   assign s3_en     = !s3_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;
   assign rsp_valid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   lda_decode u_decode (
      .clock        (clock),
      .load         (s1_en),
      .func         (req_func),
      .byte_offset  (req_byte_offset),
      .memory_dword (req_memory_dword),
      .read_ok      (req_read_ok),
      .old_register (req_old_register),
      .ctl_ff       (s1_ctl),
      .src_ff       (s1_src),
      .old_ff       (s1_old)
   );

   lda_shift u_shift (
      .clock      (clock),
      .load       (s2_en),
      .ctl        (s1_ctl),
      .src        (s1_src),
      .old        (s1_old),
      .ctl_ff     (s2_ctl),
      .shifted_ff (s2_shifted),
      .old_ff     (s2_old)
   );

   lda_merge u_merge (
      .clock     (clock),
      .load      (s3_en),
      .ctl       (s2_ctl),
      .shifted   (s2_shifted),
      .old       (s2_old),
      .result_ff (rsp_load_result)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/lda_decode.sv -----
// Stage 1: decodes load kind and offset into shift/merge controls,
// selects the addressed word. Depends on lda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lda_decode
   import lda_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [3:0]        func,
   input  wire logic [2:0]        byte_offset,
   input  wire logic [DATA_W-1:0] memory_dword,
   input  wire logic              read_ok,
   input  wire logic [DATA_W-1:0] old_register,
   output ctl_type                ctl_ff,
   output logic [DATA_W-1:0]      src_ff,
   output logic [DATA_W-1:0]      old_ff
);

   ctl_type           ctl_in;
   logic [DATA_W-1:0] src_in;
   logic              src_word;
   logic [1:0]        t;

   always_comb begin
      t        = byte_offset[1:0];
      src_word = 1'b0;
      ctl_in   = '{shift_left: 1'b0, shift_bytes: 3'd0, byte_mask: 8'h00,
                   ext_mode: EXT_KEEP, ext_width: WID_WORD};
      case (func_type'(func))
         FN_LB, FN_LBU: begin
            ctl_in.shift_bytes = 3'd7 - byte_offset;
            ctl_in.byte_mask   = 8'h01;
            ctl_in.ext_width   = WID_BYTE;
            ctl_in.ext_mode    = (func_type'(func) == FN_LB) ? EXT_SIGN : EXT_ZERO;
         end
         FN_LH, FN_LHU: begin
            ctl_in.shift_bytes = 3'd6 - {byte_offset[2:1], 1'b0};
            ctl_in.byte_mask   = 8'h03;
            ctl_in.ext_width   = WID_HALF;
            ctl_in.ext_mode    = (func_type'(func) == FN_LH) ? EXT_SIGN : EXT_ZERO;
         end
         FN_LW, FN_LWU: begin
            src_word         = 1'b1;
            ctl_in.byte_mask = 8'h0F;
            ctl_in.ext_mode  = (func_type'(func) == FN_LW) ? EXT_SIGN : EXT_ZERO;
         end
         FN_LWC1: begin
            src_word         = 1'b1;
            ctl_in.byte_mask = 8'h0F;
         end
         FN_LD: begin
            ctl_in.byte_mask = 8'hFF;
         end
         FN_LWL: begin
            src_word           = 1'b1;
            ctl_in.shift_left  = 1'b1;
            ctl_in.shift_bytes = {1'b0, t};
            ctl_in.byte_mask   = 8'h0F & ~low_byte_mask({2'b00, t});
            ctl_in.ext_mode    = EXT_SIGN;
         end
         FN_LWR: begin
            src_word           = 1'b1;
            ctl_in.shift_bytes = {1'b0, 2'd3 - t};
            ctl_in.byte_mask   = low_byte_mask({2'b00, t} + 4'd1);
            ctl_in.ext_mode    = (t == 2'd3) ? EXT_SIGN : EXT_KEEP;
         end
         FN_LDL: begin
            ctl_in.shift_left  = 1'b1;
            ctl_in.shift_bytes = byte_offset;
            ctl_in.byte_mask   = ~low_byte_mask({1'b0, byte_offset});
         end
         FN_LDR: begin
            ctl_in.shift_bytes = 3'd7 - byte_offset;
            ctl_in.byte_mask   = low_byte_mask({1'b0, byte_offset} + 4'd1);
         end
         default: begin
            ctl_in.byte_mask = 8'h00;
         end
      endcase
      // failed read: old value passes through
      if (!read_ok) begin
         ctl_in.byte_mask = 8'h00;
         ctl_in.ext_mode  = EXT_KEEP;
      end
      if (src_word) begin
         src_in = byte_offset[2] ? {32'd0, memory_dword[31:0]}
                                 : {32'd0, memory_dword[63:32]};
      end else begin
         src_in = memory_dword;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff <= ctl_in;
         src_ff <= src_in;
         old_ff <= old_register;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lda_shift.sv -----
// Stage 2: byte shifter, left for the left-partial loads, right otherwise.
// Depends on lda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lda_shift
   import lda_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire ctl_type           ctl,
   input  wire logic [DATA_W-1:0] src,
   input  wire logic [DATA_W-1:0] old,
   output ctl_type                ctl_ff,
   output logic [DATA_W-1:0]      shifted_ff,
   output logic [DATA_W-1:0]      old_ff
);

   logic [DATA_W-1:0] shifted_in;
   logic [5:0]        shamt;

   always_comb begin
      shamt = {ctl.shift_bytes, 3'b000};
      if (ctl.shift_left) begin
         shifted_in = src << shamt;
      end else begin
         shifted_in = src >> shamt;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff     <= ctl;
         shifted_ff <= shifted_in;
         old_ff     <= old;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lda_merge.sv -----
// Stage 3: byte merge with the old register value, then sign/zero extension.
// Holds the output register. Depends on lda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lda_merge
   import lda_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire ctl_type           ctl,
   input  wire logic [DATA_W-1:0] shifted,
   input  wire logic [DATA_W-1:0] old,
   output logic [DATA_W-1:0]      result_ff
);

   logic [DATA_W-1:0] bit_mask;
   logic [DATA_W-1:0] merged;
   logic [DATA_W-1:0] fill_mask;
   logic              sign_bit;
   logic [DATA_W-1:0] result_in;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         bit_mask[8*i +: 8] = {8{ctl.byte_mask[i]}};
      end
      merged = (shifted & bit_mask) | (old & ~bit_mask);
      case (ctl.ext_width)
         WID_BYTE: begin
            fill_mask = {{56{1'b1}}, 8'h00};
            sign_bit  = merged[7];
         end
         WID_HALF: begin
            fill_mask = {{48{1'b1}}, 16'h0000};
            sign_bit  = merged[15];
         end
         default: begin
            fill_mask = {{32{1'b1}}, 32'h0000_0000};
            sign_bit  = merged[31];
         end
      endcase
      case (ctl.ext_mode)
         EXT_ZERO: result_in = merged & ~fill_mask;
         EXT_SIGN: result_in = sign_bit ? (merged | fill_mask) : (merged & ~fill_mask);
         default:  result_in = merged;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lda_checker.sv -----
// Port-level checks for load_data_aligner_top, attached by bind.
// Depends on lda_pkg for load-kind codes.
`timescale 1ns / 1ps
`default_nettype none

module lda_checker
   import lda_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [3:0]  req_func,
   input wire logic [63:0] req_memory_dword,
   input wire logic        req_read_ok,
   input wire logic [63:0] req_old_register,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_load_result
);

   logic req_acc;
   assign req_acc = !reset && req_valid && !req_stall;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_load_result))
      else $error("stalled result transaction changed");

   // result is valid after the decode, shift and merge registers when the output side does not stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result transaction missing after three cycles");

   // failed read passes the old value
   a_failed_read: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_read_ok) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_load_result == $past(req_old_register, 3))
      else $error("failed read did not return old register value");

   // doubleword load returns the memory data
   a_ld: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_read_ok && req_func == FN_LD) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_load_result == $past(req_memory_dword, 3))
      else $error("doubleword load result mismatch");

endmodule

bind load_data_aligner_top lda_checker u_lda_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_func         (req_func),
   .req_memory_dword (req_memory_dword),
   .req_read_ok      (req_read_ok),
   .req_old_register (req_old_register),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_load_result  (rsp_load_result)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for load_data_aligner_top: a directed table, then random loads.
// Each response is checked against its directed table value or a behavioral model of the big-endian load aligner.
// Depends on lda_pkg and load_data_aligner_top.
`timescale 1ns / 1ps

module tb;
   import lda_pkg::*;

   localparam logic [3:0] FN_UNUSED_LO = 4'd12;
   localparam logic [3:0] FN_UNUSED_HI = 4'd15;
   localparam int RANDOM_LOADS = 1800;
   localparam int NUM_DIRECTED = 22;

   localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ZERO  = 64'h0;
   localparam logic [63:0] PAT_A = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PAT_B = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] PAT_C = 64'h8899_AABB_CCDD_EEFF;
   localparam logic [63:0] TOP_1 = 64'h8000_0000_0000_0000;

   typedef struct {
      logic [3:0]  fn;
      logic [2:0]  off;
      logic [63:0] dword;
      logic        ok;
      logic [63:0] old_reg;
      logic        typed;
      logic [63:0] want;
   } load_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_func = '0;
   logic [2:0]  req_byte_offset = '0;
   logic [63:0] req_memory_dword = '0;
   logic        req_read_ok = 1'b0;
   logic [63:0] req_old_register = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_load_result;

   logic [63:0]   expected_results[$];
   int            mismatch_count = 0;
   logic [9:0]    phase_cnt = '0;
   int            stall_hold = 0;
   load_case_type directed_loads [0:NUM_DIRECTED-1];

   wire calm = (phase_cnt[9:8] == 2'b11);

   load_data_aligner_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_byte_offset  (req_byte_offset),
      .req_memory_dword (req_memory_dword),
      .req_read_ok      (req_read_ok),
      .req_old_register (req_old_register),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_load_result  (rsp_load_result)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      phase_cnt <= phase_cnt + 10'd1;
   end

   function automatic logic [63:0] sign_ext_word(input logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

   function automatic logic [63:0] predict_load_result(input logic [3:0] fn,
                                                       input logic [2:0] off,
                                                       input logic [63:0] dw,
                                                       input logic ok,
                                                       input logic [63:0] old_reg);
      logic [7:0]  lane8;
      logic [15:0] lane16;
      logic [31:0] w32;
      logic [31:0] v32;
      logic [63:0] low_mask;
      logic [1:0]  t;
      if (!ok)
         return old_reg;
      lane8  = dw[8 * (7 - off) +: 8];
      lane16 = dw[16 * (3 - off[2:1]) +: 16];
      w32    = off[2] ? dw[31:0] : dw[63:32];
      t      = off[1:0];
      case (fn)
         FN_LB:   return {{56{lane8[7]}}, lane8};
         FN_LBU:  return {56'b0, lane8};
         FN_LH:   return {{48{lane16[15]}}, lane16};
         FN_LHU:  return {48'b0, lane16};
         FN_LW:   return sign_ext_word(w32);
         FN_LWU:  return {32'b0, w32};
         FN_LWC1: return {old_reg[63:32], w32};
         FN_LD:   return dw;
         FN_LWL: begin
            low_mask = (64'h1 << (8 * t)) - 64'h1;
            v32 = (w32 << (8 * t)) | (old_reg[31:0] & low_mask[31:0]);
            return sign_ext_word(v32);
         end
         FN_LWR: begin
            low_mask = (64'h1 << (8 * (t + 1))) - 64'h1;
            v32 = (w32 >> (8 * (3 - t))) | (old_reg[31:0] & ~low_mask[31:0]);
            return (t == 2'd3) ? sign_ext_word(v32) : {old_reg[63:32], v32};
         end
         FN_LDL: begin
            low_mask = (64'h1 << (8 * off)) - 64'h1;
            return (dw << (8 * off)) | (old_reg & low_mask);
         end
         FN_LDR: begin
            if (off == 3'd7)
               return dw;
            low_mask = (64'h1 << (8 * (off + 1))) - 64'h1;
            return (dw >> (8 * (7 - off))) | (old_reg & ~low_mask);
         end
         default: return old_reg;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_load(input load_case_type lc);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= lc.fn;
      req_byte_offset  <= lc.off;
      req_memory_dword <= lc.dword;
      req_read_ok      <= lc.ok;
      req_old_register <= lc.old_reg;
      do @(posedge clock); while (req_stall);
      if (lc.typed)
         expected_results.push_back(lc.want);
      else
         expected_results.push_back(predict_load_result(lc.fn, lc.off, lc.dword, lc.ok,
                                                        lc.old_reg));
   endtask

   function automatic logic [63:0] random_dword();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return ONES;
      if (r == 1)
         return ZERO;
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin : rsp_backpressure
      int r;
      r = $urandom_range(0, 99);
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (calm || r < 65) begin
         rsp_stall <= 1'b0;
      end else if (r < 93) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 2);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(8, 40);
      end
   end

   always @(posedge clock) begin : result_check
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("load_result: unexpected transaction, actual %h", rsp_load_result);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_load_result !== want) begin
               $error("load_result: expected %h actual %h", want, rsp_load_result);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("load_data_aligner_top test failed");
      $finish;
   end

   initial begin
      load_case_type lc;
      int r;
      directed_loads = '{
         '{FN_LD,        3'd0, ONES,  1'b1, ZERO,  1'b1, ONES},
         '{FN_LD,        3'd5, ZERO,  1'b1, ONES,  1'b1, ZERO},
         '{FN_LB,        3'd0, TOP_1, 1'b1, PAT_B, 1'b1, 64'hFFFF_FFFF_FFFF_FF80},
         '{FN_LBU,       3'd0, TOP_1, 1'b1, PAT_B, 1'b1, 64'h80},
         '{FN_LB,        3'd7, 64'h7F, 1'b1, ONES, 1'b1, 64'h7F},
         '{FN_LH,        3'd1, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LHU,       3'd6, ONES,  1'b1, ZERO,  1'b1, 64'hFFFF},
         '{FN_LW,        3'd0, TOP_1, 1'b1, ZERO,  1'b1, 64'hFFFF_FFFF_8000_0000},
         '{FN_LWU,       3'd7, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LWC1,      3'd4, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LWL,       3'd0, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LWL,       3'd3, PAT_C, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LWR,       3'd3, PAT_C, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LWR,       3'd1, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LDL,       3'd0, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LDL,       3'd7, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LDR,       3'd0, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LDR,       3'd7, PAT_A, 1'b1, PAT_B, 1'b0, ZERO},
         '{FN_LD,        3'd2, PAT_A, 1'b0, PAT_B, 1'b1, PAT_B},
         '{FN_LWL,       3'd1, PAT_A, 1'b0, ONES,  1'b1, ONES},
         '{FN_UNUSED_LO, 3'd0, PAT_A, 1'b1, PAT_B, 1'b1, PAT_B},
         '{FN_UNUSED_HI, 3'd7, ONES,  1'b1, ZERO,  1'b1, ZERO}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_load(directed_loads[i]);

      for (int i = 0; i < RANDOM_LOADS; i++) begin
         r = $urandom_range(0, 99);
         lc.fn      = (r < 95) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
         lc.off     = 3'($urandom_range(0, 7));
         lc.dword   = random_dword();
         lc.ok      = ($urandom_range(0, 9) != 0);
         lc.old_reg = random_dword();
         lc.typed   = 1'b0;
         lc.want    = ZERO;
         send_load(lc);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("load_data_aligner_top test passed");
      else
         $display("load_data_aligner_top test failed");
      $finish;
   end

endmodule
